### rtl/core/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg: shared types and constants of the triangle circumcircle unit
// Word formats, pipeline widths and the per-stage struct of the chain.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned FracBitsDef  = 8;
  localparam int unsigned InW          = 16;
  localparam int unsigned OutW         = 32;

  // quotient bits kept by the divider chain; offsets cap at 2^48
  localparam int unsigned QuotBits = 50;
  localparam int unsigned OfsCapLg = 48;
  // numerator magnitude: |num| < 2^(3*(c+1)+2), shifted by frac, plus half
  localparam int unsigned NumW     = 3 * 25 + 2 + 16 + 2;
  localparam int unsigned DetW     = 2 * 25 + 2;
  localparam int unsigned RemW     = DetW + 2;

  typedef struct packed {
    logic signed [InW-1:0] ax;
    logic signed [InW-1:0] ay;
    logic signed [InW-1:0] bx;
    logic signed [InW-1:0] by;
    logic signed [InW-1:0] cx;
    logic signed [InW-1:0] cy;
  } tri_in_t;

  typedef struct packed {
    logic signed [OutW-1:0] center_x;
    logic signed [OutW-1:0] center_y;
    logic        [OutW-1:0] radius;
    logic                   degenerate;
    logic                   saturated;
  } tri_out_t;

  // one word in flight through the divider chain
  typedef struct packed {
    logic              vld;
    logic              degen;
    logic [InW+1-1:0]  ax;      // sign-extended coordinates kept wide enough
    logic [InW+1-1:0]  ay;
    logic [RemW-1:0]   dvs;     // 2*|det|
    logic [NumW-1:0]   nx;      // numerator magnitudes, shifted in from msb
    logic [NumW-1:0]   ny;
    logic [RemW-1:0]   rx;      // partial remainders
    logic [RemW-1:0]   ry;
    logic [QuotBits:0] qx;      // msb collects overflow beyond the kept bits
    logic [QuotBits:0] qy;
    logic              sx;      // result signs
    logic              sy;
  } div_word_t;

endpackage

### rtl/core/triangle_circumcircle_unit.sv
// Pipeline: 3 front stages, NumW divider cells and 37 back stages lie between
//   start and done_o.
// Throughput: one word per clock; busy is tied low, the chain never stalls.
// Stages come from the restoring divider chain (one quotient bit per cell) and root chain.
// Reset clears all valid bits; payload registers are not reset.
// Results appear for one cycle with done_o; the receiver cannot stall.
// ----------------------------------------------------------------------------
// triangle_circumcircle_unit: circumcenter and circumradius of a triangle
// Pipelined chain of divider and root cells, one triangle per clock.
// ----------------------------------------------------------------------------
module triangle_circumcircle_unit import tcc_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  tri_in_t  tri_i,
  output logic     done_o,
  output tri_out_t res_o
);

  div_word_t chain [NumW+1];

  assign busy = 1'b0;

  tcc_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (start),
    .tri_i (tri_i),
    .word_o(chain[0])
  );

  for (genvar k = 0; k < NumW; k++) begin : g_div
    tcc_div_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .word_i(chain[k]),
      .word_o(chain[k+1])
    );
  end

  tcc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .word_i(chain[NumW]),
    .vld_o (done_o),
    .res_o (res_o)
  );

endmodule

### rtl/core/tcc_div_cell.sv
// ----------------------------------------------------------------------------
// tcc_div_cell: one restoring-division step for both offsets
// Shifts one numerator bit into each remainder and subtracts the divisor when it fits.
// ----------------------------------------------------------------------------
module tcc_div_cell import tcc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  div_word_t word_i,
  output div_word_t word_o
);

  div_word_t     word_d, word_q;
  logic          vld_q;
  logic [RemW:0] tx, ty;
  logic          gx, gy;

  always_comb begin
    word_d = word_i;
    tx = {word_i.rx, word_i.nx[NumW-1]};
    ty = {word_i.ry, word_i.ny[NumW-1]};
    gx = (tx >= {1'b0, word_i.dvs}) && (word_i.dvs != '0);
    gy = (ty >= {1'b0, word_i.dvs}) && (word_i.dvs != '0);
    word_d.nx = {word_i.nx[NumW-2:0], 1'b0};
    word_d.ny = {word_i.ny[NumW-2:0], 1'b0};
    word_d.rx = gx ? RemW'(tx - {1'b0, word_i.dvs}) : tx[RemW-1:0];
    word_d.ry = gy ? RemW'(ty - {1'b0, word_i.dvs}) : ty[RemW-1:0];
    // sticky overflow in the top quotient bit
    word_d.qx = {word_i.qx[QuotBits] | word_i.qx[QuotBits-1], word_i.qx[QuotBits-2:0], gx};
    word_d.qy = {word_i.qy[QuotBits] | word_i.qy[QuotBits-1], word_i.qy[QuotBits-2:0], gy};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= word_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  // valid comes from the reset flop, payload from the plain one
  always_comb begin
    word_o     = word_q;
    word_o.vld = vld_q;
  end

endmodule

### rtl/core/tcc_front.sv
// ----------------------------------------------------------------------------
// tcc_front: determinant and numerator stages
// Differences, squared norms, products, then magnitudes and rounding bias.
// ----------------------------------------------------------------------------
module tcc_front import tcc_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      vld_i,
  input  tri_in_t   tri_i,
  output div_word_t word_o
);

  localparam int unsigned DW = COORD_BITS + 1;   // difference width
  localparam int unsigned SW = 2 * DW + 1;       // norm / det width
  localparam int unsigned PW = DW + SW;          // product width

  // stage 1: differences
  logic                 v1_q;
  logic signed [DW-1:0] ux_q, uy_q, vx_q, vy_q, ax1_q, ay1_q;
  // stage 2: products of differences
  logic                 v2_q;
  logic signed [SW-1:0] det_q, nu_q, nv_q;
  logic signed [DW-1:0] ux2_q, uy2_q, vx2_q, vy2_q, ax2_q, ay2_q;
  // stage 3: numerators
  logic                  v3_q;
  logic signed [PW:0]    numx_q, numy_q;
  logic signed [SW-1:0]  det3_q;
  logic signed [DW-1:0]  ax3_q, ay3_q;

  logic signed [COORD_BITS-1:0] axc, ayc, bxc, byc, cxc, cyc;
  assign axc = COORD_BITS'(tri_i.ax);
  assign ayc = COORD_BITS'(tri_i.ay);
  assign bxc = COORD_BITS'(tri_i.bx);
  assign byc = COORD_BITS'(tri_i.by);
  assign cxc = COORD_BITS'(tri_i.cx);
  assign cyc = COORD_BITS'(tri_i.cy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ux_q  <= DW'(bxc) - DW'(axc);
    uy_q  <= DW'(byc) - DW'(ayc);
    vx_q  <= DW'(cxc) - DW'(axc);
    vy_q  <= DW'(cyc) - DW'(ayc);
    ax1_q <= DW'(axc);
    ay1_q <= DW'(ayc);

    det_q <= SW'(ux_q * vy_q) - SW'(uy_q * vx_q);
    nu_q  <= SW'(ux_q * ux_q) + SW'(uy_q * uy_q);
    nv_q  <= SW'(vx_q * vx_q) + SW'(vy_q * vy_q);
    ux2_q <= ux_q; uy2_q <= uy_q; vx2_q <= vx_q; vy2_q <= vy_q;
    ax2_q <= ax1_q; ay2_q <= ay1_q;

    numx_q <= (PW+1)'(vy2_q * nu_q) - (PW+1)'(uy2_q * nv_q);
    numy_q <= (PW+1)'(ux2_q * nv_q) - (PW+1)'(vx2_q * nu_q);
    det3_q <= det_q;
    ax3_q  <= ax2_q;
    ay3_q  <= ay2_q;
  end

  logic [PW:0]   mx, my;
  logic [SW-1:0] ad;
  always_comb begin
    mx = numx_q[PW] ? (PW+1)'(-numx_q) : numx_q;
    my = numy_q[PW] ? (PW+1)'(-numy_q) : numy_q;
    ad = det3_q[SW-1] ? SW'(-det3_q) : det3_q;
    word_o       = '0;
    word_o.vld   = v3_q;
    word_o.degen = (det3_q == '0);
    word_o.ax    = (InW+1)'(ax3_q);
    word_o.ay    = (InW+1)'(ay3_q);
    word_o.dvs   = RemW'({ad, 1'b0});
    word_o.nx    = NumW'((NumW'(mx) << FRAC_BITS) + NumW'(ad));
    word_o.ny    = NumW'((NumW'(my) << FRAC_BITS) + NumW'(ad));
    word_o.sx    = numx_q[PW] ^ det3_q[SW-1];
    word_o.sy    = numy_q[PW] ^ det3_q[SW-1];
  end

endmodule

### rtl/core/tcc_back.sv
// ----------------------------------------------------------------------------
// tcc_back: center add, radius square root and saturation
// Squares the offsets, runs a chain of root cells, then clips each field.
// ----------------------------------------------------------------------------
module tcc_back import tcc_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  div_word_t word_i,
  output logic      vld_o,
  output tri_out_t  res_o
);

  localparam int unsigned RootSteps = 33;

  // stage A: capped signed offsets and centers
  logic              va_q, dga_q, sata_q;
  logic [OfsCapLg:0] mxa_q, mya_q;
  logic [OutW-1:0]   cxa_q, cya_q;

  logic [OfsCapLg:0]           mx, my;
  logic signed [OfsCapLg+1:0]  ox, oy;
  logic signed [OfsCapLg+2:0]  cx, cy;
  logic                        sx, sy;

  always_comb begin
    mx = (word_i.qx[QuotBits:OfsCapLg+1] != '0 || word_i.qx[OfsCapLg:0] > (1 << OfsCapLg))
         ? (OfsCapLg+1)'(1) << OfsCapLg : word_i.qx[OfsCapLg:0];
    my = (word_i.qy[QuotBits:OfsCapLg+1] != '0 || word_i.qy[OfsCapLg:0] > (1 << OfsCapLg))
         ? (OfsCapLg+1)'(1) << OfsCapLg : word_i.qy[OfsCapLg:0];
    ox = word_i.sx ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
    oy = word_i.sy ? -$signed({1'b0, my}) : $signed({1'b0, my});
    cx = ((OfsCapLg+3)'($signed(word_i.ax)) <<< FRAC_BITS) + (OfsCapLg+3)'(ox);
    cy = ((OfsCapLg+3)'($signed(word_i.ay)) <<< FRAC_BITS) + (OfsCapLg+3)'(oy);
    sx = (cx > (OfsCapLg+3)'(32'sh7fffffff)) || (cx < -(OfsCapLg+3)'(64'sh80000000));
    sy = (cy > (OfsCapLg+3)'(32'sh7fffffff)) || (cy < -(OfsCapLg+3)'(64'sh80000000));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else         va_q <= word_i.vld;
  end

  always_ff @(posedge clk_i) begin
    dga_q  <= word_i.degen;
    mxa_q  <= mx;
    mya_q  <= my;
    sata_q <= sx | sy;
    cxa_q  <= sx ? (cx[OfsCapLg+2] ? 32'h80000000 : 32'h7fffffff) : cx[OutW-1:0];
    cya_q  <= sy ? (cy[OfsCapLg+2] ? 32'h80000000 : 32'h7fffffff) : cy[OutW-1:0];
  end

  // stage B/C: squares of the low 32 bits plus a flag for wider offsets, to keep multipliers 32 bits wide
  logic            vb_q, dgb_q, satb_q, bigb_q;
  logic [63:0]     sxb_q, syb_q;
  logic [OutW-1:0] cxb_q, cyb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else         vb_q <= va_q;
  end
  always_ff @(posedge clk_i) begin
    dgb_q  <= dga_q;
    satb_q <= sata_q;
    bigb_q <= (mxa_q[OfsCapLg:32] != '0) || (mya_q[OfsCapLg:32] != '0);
    sxb_q  <= mxa_q[31:0] * mxa_q[31:0];
    syb_q  <= mya_q[31:0] * mya_q[31:0];
    cxb_q  <= cxa_q;
    cyb_q  <= cya_q;
  end

  logic            vc_q, dgc_q, satc_q, bigc_q;
  logic [64:0]     sc_q;
  logic [OutW-1:0] cxc_q, cyc_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else         vc_q <= vb_q;
  end
  always_ff @(posedge clk_i) begin
    dgc_q  <= dgb_q;
    satc_q <= satb_q;
    bigc_q <= bigb_q;
    sc_q   <= {1'b0, sxb_q} + {1'b0, syb_q};
    cxc_q  <= cxb_q;
    cyc_q  <= cyb_q;
  end

  // root chain: one result bit per stage but the last, which rounds; radicand 64 bits
  logic            rv_q   [RootSteps];
  logic            rdg_q  [RootSteps];
  logic            rsat_q [RootSteps];
  logic            rbig_q [RootSteps];
  logic [63:0]     rs_q   [RootSteps];
  logic [65:0]     rr_q   [RootSteps];   // remainder
  logic [32:0]     rq_q   [RootSteps];
  logic [OutW-1:0] rcx_q  [RootSteps];
  logic [OutW-1:0] rcy_q  [RootSteps];

  for (genvar k = 0; k < RootSteps; k++) begin : g_root
    logic        pv, pdg, psat, pbig;
    logic [63:0] ps;
    logic [65:0] pr;
    logic [32:0] pq;
    logic [OutW-1:0] pcx, pcy;
    logic [65:0] tr, trial;
    if (k == 0) begin : g_first
      assign pv = vc_q; assign pdg = dgc_q; assign psat = satc_q;
      assign pbig = bigc_q | sc_q[64];
      assign ps = sc_q[63:0]; assign pr = '0; assign pq = '0;
      assign pcx = cxc_q; assign pcy = cyc_q;
    end else begin : g_next
      assign pv = rv_q[k-1]; assign pdg = rdg_q[k-1]; assign psat = rsat_q[k-1];
      assign pbig = rbig_q[k-1];
      assign ps = rs_q[k-1]; assign pr = rr_q[k-1]; assign pq = rq_q[k-1];
      assign pcx = rcx_q[k-1]; assign pcy = rcy_q[k-1];
    end
    always_comb begin
      if (k < 32) begin
        tr    = {pr[63:0], ps[63:62]};
        trial = {31'b0, pq, 2'b01};
      end else begin
        // last stage settles rounding: round up when rem > root
        tr    = pr;
        trial = {33'b0, pq} + 66'd1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) rv_q[k] <= 1'b0;
      else         rv_q[k] <= pv;
    end
    always_ff @(posedge clk_i) begin
      rdg_q[k]  <= pdg;
      rsat_q[k] <= psat;
      rbig_q[k] <= pbig;
      rs_q[k]   <= {ps[61:0], 2'b00};
      rcx_q[k]  <= pcx;
      rcy_q[k]  <= pcy;
      if (k < 32) begin
        if (tr >= trial) begin
          rr_q[k] <= tr - trial;
          rq_q[k] <= {pq[31:0], 1'b1};
        end else begin
          rr_q[k] <= tr;
          rq_q[k] <= {pq[31:0], 1'b0};
        end
      end else begin
        rr_q[k] <= pr;
        rq_q[k] <= (tr > {33'b0, pq}) ? 33'(trial) : pq;
      end
    end
  end

  localparam int unsigned L = RootSteps - 1;
  logic rclip;
  assign rclip = rbig_q[L] | rq_q[L][32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_o <= 1'b0;
    else         vld_o <= rv_q[L];
  end

  always_ff @(posedge clk_i) begin
    if (rdg_q[L]) begin
      res_o <= '{center_x: '0, center_y: '0, radius: '0, degenerate: 1'b1, saturated: 1'b0};
    end else begin
      res_o.center_x   <= rcx_q[L];
      res_o.center_y   <= rcy_q[L];
      res_o.radius     <= rclip ? 32'hffffffff : rq_q[L][31:0];
      res_o.degenerate <= 1'b0;
      res_o.saturated  <= rsat_q[L] | rclip;
    end
  end

endmodule
